>>> src/umpq_pkg.sv
// Package for the unordered max-priority queue unit.
// Holds the field widths, operation codes, status codes and the controller state type.
// No dependencies.
`default_nettype none

package umpq_pkg;

    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 5;

    // Operation codes of an input word.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> src/umpq_if.sv
// Handshake interfaces for the input and result channels of the queue unit.
// Depends on umpq_pkg for the field widths.
`default_nettype none

interface umpq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic signed [umpq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

interface umpq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [umpq_pkg::STATUS_W-1:0] status;
    logic signed [umpq_pkg::VALUE_W-1:0]  result_value;
    logic        [umpq_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output result_value, output entry_count,
                    input ready);
    modport sink (input valid, input status, input result_value, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> src/unordered_max_priority_queue_unit.sv
// Insert and underflowing extract: the result goes from the done state to the output
// register once it is free; the next word is taken after that. Successful extract: a
// scan token walks the cell chain one cell per cycle, then the result goes the same way.
// The chain length of DEPTH cells sets the extract latency.
// Synchronous active-low reset clears the count, the scan and the output; entries are not
// cleared and only entries below the count are ever used.
`default_nettype none

module unordered_max_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    umpq_in_if.sink          i_in,
    umpq_out_if.source       o_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW = umpq_pkg::VALUE_W;
    localparam int OUT_CNT_W = umpq_pkg::COUNT_W;
    localparam int TOK_W = 2 * VW + IDX_W + 2;
    localparam int WR_W = VW + IDX_W + 1;

    // The scan token carries the running maximum, where it was found and the value of
    // the last stored entry, which refills the slot that the maximum leaves.
    typedef struct packed {
        logic                  valid;
        logic                  have;
        logic signed [VW-1:0]  max;
        logic [IDX_W-1:0]      best;
        logic signed [VW-1:0]  last;
    } t_token;

    // One write command is broadcast to every cell; the cell whose index matches loads it.
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic signed [VW-1:0]  data;
    } t_write;

    umpq_pkg::t_state     r_state;
    umpq_pkg::t_state     n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    umpq_pkg::t_status    r_res_status;
    umpq_pkg::t_status    n_res_status;
    logic signed [VW-1:0] r_res_value;
    logic signed [VW-1:0] n_res_value;
    logic                 r_out_valid;
    umpq_pkg::t_status    r_out_status;
    logic signed [VW-1:0] r_out_value;
    logic [CNT_W-1:0]     r_out_count;
    logic                 w_in_accept;
    logic                 w_out_load;
    t_token               w_tok_launch;
    t_token               w_tok_exit;
    t_write               w_wr;
    logic [TOK_W-1:0]     w_chain [DEPTH+1];

    assign i_in.ready = (r_state == umpq_pkg::S_IDLE);
    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == umpq_pkg::S_DONE) && (!r_out_valid || o_out.ready);

    assign w_chain[0] = w_tok_launch;
    assign w_tok_exit = t_token'(w_chain[DEPTH]);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        umpq_cell #(
            .DEPTH    (DEPTH),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1]),
            .i_wr    (WR_W'(w_wr))
        );
    end

    // Controller: a non-full insert writes at the count, a non-empty extract launches a
    // token and, when it leaves the chain, moves the last entry into the maximum's slot.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_res_status = r_res_status;
        n_res_value = r_res_value;
        w_tok_launch = '0;
        w_wr = '0;
        unique case (r_state)
            umpq_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_res_status = umpq_pkg::ST_OK;
                    n_res_value = '0;
                    n_state = umpq_pkg::S_DONE;
                    if (i_in.operation == umpq_pkg::OP_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_res_status = umpq_pkg::ST_OVERFLOW;
                        end else begin
                            w_wr.en = 1'b1;
                            w_wr.idx = IDX_W'(r_count);
                            w_wr.data = i_in.value;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_res_status = umpq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_tok_launch.valid = 1'b1;
                        n_state = umpq_pkg::S_SCAN;
                    end
                end
            end
            umpq_pkg::S_SCAN: begin
                if (w_tok_exit.valid) begin
                    w_wr.en = 1'b1;
                    w_wr.idx = w_tok_exit.best;
                    w_wr.data = w_tok_exit.last;
                    n_count = r_count - CNT_W'(1);
                    n_res_value = w_tok_exit.max;
                    n_state = umpq_pkg::S_DONE;
                end
            end
            umpq_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = umpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = umpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= umpq_pkg::S_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_value <= n_res_value;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_value <= r_res_value;
            r_out_count <= r_count;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.result_value = r_out_value;
    assign o_out.entry_count = OUT_CNT_W'(r_out_count);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds capacity");

    // A token leaves the chain only while the controller waits for it.
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_exit.valid |-> (r_state == umpq_pkg::S_SCAN))
        else $error("scan token left the chain outside a scan");

    // An extract on a non-empty queue always starts a scan.
    a_extract_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_in.operation == umpq_pkg::OP_EXTRACT) && (r_count != '0))
        |=> (r_state == umpq_pkg::S_SCAN))
        else $error("extract did not start a scan");

    // A successful extract removes exactly one entry.
    a_extract_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == umpq_pkg::S_SCAN) && w_tok_exit.valid)
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("extract did not shrink the count by one");

endmodule

`default_nettype wire

>>> src/umpq_cell.sv
// One storage cell of the queue chain: holds one entry and updates the scan token.
// Depends on umpq_pkg for the value width.
`default_nettype none

module umpq_cell #(
    parameter int DEPTH = 16,
    parameter int CELL_IDX = 0
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [$clog2(DEPTH+1)-1:0]      i_count,
    input  wire logic [2*umpq_pkg::VALUE_W+$clog2(DEPTH)+1:0] i_tok,
    output logic      [2*umpq_pkg::VALUE_W+$clog2(DEPTH)+1:0] o_tok,
    input  wire logic [umpq_pkg::VALUE_W+$clog2(DEPTH):0]     i_wr
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW = umpq_pkg::VALUE_W;

    typedef struct packed {
        logic                  valid;
        logic                  have;
        logic signed [VW-1:0]  max;
        logic [IDX_W-1:0]      best;
        logic signed [VW-1:0]  last;
    } t_token;

    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic signed [VW-1:0]  data;
    } t_write;

    t_token               w_tok_in;
    t_token               n_tok;
    t_token               r_tok;
    t_write               w_wr;
    logic signed [VW-1:0] r_entry;
    logic                 w_in_use;
    logic                 w_is_last;

    assign w_tok_in = t_token'(i_tok);
    assign w_wr = t_write'(i_wr);
    assign o_tok = r_tok;

    assign w_in_use = CNT_W'(CELL_IDX) < i_count;
    assign w_is_last = CNT_W'(CELL_IDX + 1) == i_count;

    always_ff @(posedge i_clk) begin
        if (w_wr.en && (w_wr.idx == IDX_W'(CELL_IDX))) begin
            r_entry <= w_wr.data;
        end
    end

    // Strictly greater keeps the lowest index among equal maxima.
    always_comb begin
        n_tok = w_tok_in;
        if (w_tok_in.valid && w_in_use) begin
            if (!w_tok_in.have || (r_entry > w_tok_in.max)) begin
                n_tok.have = 1'b1;
                n_tok.max = r_entry;
                n_tok.best = IDX_W'(CELL_IDX);
            end
            if (w_is_last) begin
                n_tok.last = r_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire
